/* hw/rtl/prc_pkg.sv */
// package for the rotation stream cipher: widths, register indexes and
// the generator step, mod-96 reduction and band rotation functions
// no dependencies
package prc_pkg;

    // field and register widths
    localparam int ByteW  = 8;
    localparam int StateW = 17;
    localparam int CfgW   = 17;
    localparam int CfgIdxW = 1;
    localparam int KeyW   = 7;

    // constants of the generator and the printable band
    localparam logic [23:0] Mult     = 24'd75;
    localparam logic [17:0] Modulus  = 18'd65537;
    localparam logic [6:0]  RotSpan  = 7'd96;
    localparam logic [7:0]  RotLow   = 8'd32;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;
    typedef logic [StateW-1:0]  t_state;
    typedef logic [ByteW-1:0]   t_byte;

    // configuration register indexes
    localparam t_cfg_idx CFG_KEY_SEED    = 1'b0;
    localparam t_cfg_idx CFG_CIPHER_MODE = 1'b1;

    // one generator step: s*75 mod 65537 by the 16-bit fold
    function automatic t_state lehmer_step(input t_state s);
        logic [23:0] prod;
        logic [17:0] diff;
        logic [17:0] fixed;
        prod  = 24'(s) * Mult;
        diff  = {2'b00, prod[15:0]} - {10'b0, prod[23:16]};
        fixed = diff[17] ? (diff + Modulus) : diff;
        return fixed[StateW-1:0];
    endfunction

    // s mod 96 = 32 * ((s >> 5) mod 3) + s[4:0]; mod 3 by summing base-4 digits
    function automatic logic [KeyW-1:0] mod96(input t_state s);
        logic [11:0] q;
        logic [4:0]  sum1;
        logic [2:0]  sum2;
        logic [2:0]  sum3;
        logic [1:0]  rem3;
        q    = s[16:5];
        sum1 = 5'(q[1:0]) + 5'(q[3:2]) + 5'(q[5:4])
             + 5'(q[7:6]) + 5'(q[9:8]) + 5'(q[11:10]);
        sum2 = 3'(sum1[1:0]) + 3'(sum1[3:2]) + 3'(sum1[4]);
        sum3 = 3'(sum2[1:0]) + 3'(sum2[2]);
        rem3 = (sum3 >= 3'd3) ? 2'(sum3 - 3'd3) : sum3[1:0];
        return {rem3, s[4:0]};
    endfunction

    // rotate a printable byte within 32..127, other codes pass unchanged
    function automatic t_byte rotate_byte(input t_byte b, input logic [KeyW-1:0] k,
                                          input logic decrypt);
        logic [6:0] pos;
        logic [7:0] sum;
        logic [6:0] wrapped;
        pos     = 7'(b - RotLow);
        sum     = decrypt ? (8'(pos) + 8'(RotSpan) - 8'(k)) : (8'(pos) + 8'(k));
        wrapped = (sum >= 8'(RotSpan)) ? 7'(sum - 8'(RotSpan)) : sum[6:0];
        if (b[7] || (b[6:5] == 2'b00)) begin
            return b;
        end
        return 8'(wrapped) + RotLow;
    endfunction

endpackage

/* hw/rtl/prng_rotation_stream_cipher.sv */
// top level of the rotation stream cipher: generator stage and output stage
// depends on prc_pkg
//
// usage
// - input channel: i_in_valid with i_data_byte and i_restart, o_in_stall back;
//   a transfer happens on a clock edge with valid high and stall low
// - output channel: o_out_valid with o_out_byte, i_out_stall from the receiver
// - one result byte per input byte, in order; one byte per clock sustained while
//   the receiver does not stall
// - each byte sits in the generator stage, then loads the output register
// - the generator register steps once per input transfer, so its recurrence
//   (constant multiply plus fold) is the register loop that sets the rate
// - i_restart reloads the generator from key_seed before stepping for that byte
// - config: i_cfg_wr_en writes key_seed (index 0) or cipher_mode (index 1);
//   writes are meant for idle periods only
// - reset (synchronous, active low): key_seed = 1, cipher_mode = 0,
//   generator state = 1, both stages empty
// - a stalled receiver holds the output register; the generator stage then
//   holds too and o_in_stall rises once both stages are full
module prng_rotation_stream_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  prc_pkg::t_cfg_idx         i_cfg_index,
    input  logic [prc_pkg::CfgW-1:0]  i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [prc_pkg::ByteW-1:0] i_data_byte,
    input  logic                      i_restart,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [prc_pkg::ByteW-1:0] o_out_byte
);
    import prc_pkg::*;

    t_state r_key_seed;
    logic   r_cipher_mode;
    t_state r_state;
    t_state n_state;
    logic   r_s1_valid;
    t_byte  r_s1_byte;
    logic   r_out_valid;
    t_byte  r_out_byte;
    t_byte  n_out_byte;
    logic   in_xfer;
    logic   s1_move;
    logic   out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed    <= t_state'(1);
            r_cipher_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_SEED:    r_key_seed    <= i_cfg_wdata[StateW-1:0];
                CFG_CIPHER_MODE: r_cipher_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake between the stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // generator step, with optional reload from the key
    assign n_state = lehmer_step(i_restart ? r_key_seed : r_state);

    // generator stage: state register and the byte it belongs to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= t_state'(1);
            r_s1_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_byte <= i_data_byte;
        end
    end

    // rotation by the new state mod 96
    assign n_out_byte = rotate_byte(r_s1_byte, mod96(r_state), r_cipher_mode);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_byte <= n_out_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

`ifndef NO_ASSERTIONS
    // the fold keeps the generator in 0..65536
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= t_state'(65536))
        else $error("generator state out of range");

    // the generator only steps on an input transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_state))
        else $error("generator stepped without a transfer");

    // an input transfer always fills the generator stage
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_valid)
        else $error("generator stage lost a byte");

    // rotation keeps a byte inside or outside the printable band
    a_band_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> ((r_out_byte[7] || r_out_byte[6:5] == 2'b00)
                     == ($past(r_s1_byte[7]) || $past(r_s1_byte[6:5]) == 2'b00)))
        else $error("rotation left the printable band");
`endif

endmodule

/* tb/keystream_checker.sv */
// checker for the rotation stream cipher: mirrors the config registers and the
// generator, predicts every output byte and compares it on the output channel
// depends on prc_pkg for the port types and register indexes
`timescale 1ns / 100ps

module keystream_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  prc_pkg::t_cfg_idx         i_cfg_index,
    input  logic [prc_pkg::CfgW-1:0]  i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [prc_pkg::ByteW-1:0] i_data_byte,
    input  logic                      i_restart,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [prc_pkg::ByteW-1:0] i_out_byte,
    output int                        o_pending,
    output int                        o_fail_count
);

    // generator and band constants
    localparam int unsigned LehmerMult = 75;
    localparam int          LehmerMod  = 65537;
    localparam int unsigned BandLow    = 32;
    localparam int unsigned BandSpan   = 96;

    // mirrored registers and generator state
    prc_pkg::t_state key_seed_q;
    logic            decrypt_q;
    prc_pkg::t_state gen_state;
    prc_pkg::t_byte  expected_out_bytes[$];

    // state * 75 mod 65537: low half minus high part, wrapped back if negative
    function automatic prc_pkg::t_state keystream_step(input prc_pkg::t_state s);
        logic [23:0] prod;
        int          folded;
        prod   = 24'(s) * 24'(LehmerMult);
        folded = int'({16'b0, prod[15:0]}) - int'({24'b0, prod[23:16]});
        if (folded < 0) begin
            folded += LehmerMod;
        end
        return prc_pkg::t_state'(folded);
    endfunction

    // rotate a printable code within the band by state mod 96
    function automatic prc_pkg::t_byte rotate_in_band(input prc_pkg::t_byte b,
                                                      input prc_pkg::t_state s,
                                                      input logic dec);
        int unsigned shift;
        int unsigned pos;
        shift = int'(s) % BandSpan;
        if (int'(b) < BandLow || int'(b) >= BandLow + BandSpan) begin
            return b;
        end
        pos = int'(b) - BandLow;
        if (dec) begin
            pos = (pos + BandSpan - shift) % BandSpan;
        end else begin
            pos = (pos + shift) % BandSpan;
        end
        return prc_pkg::t_byte'(pos + BandLow);
    endfunction

    // output check first, then prediction for the input transfer, then config
    always @(posedge i_clk) begin
        prc_pkg::t_byte want;
        if (!i_rst_n) begin
            key_seed_q   = 17'd1;
            decrypt_q    = 1'b0;
            gen_state    = 17'd1;
            o_fail_count = 0;
            expected_out_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_out_bytes.size() == 0) begin
                    $error("out_byte: unexpected transfer, actual %0d", i_out_byte);
                    o_fail_count++;
                end else begin
                    want = expected_out_bytes.pop_front();
                    if (i_out_byte !== want) begin
                        $error("out_byte mismatch: expected %0d actual %0d",
                               want, i_out_byte);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_restart) begin
                    gen_state = key_seed_q;
                end
                gen_state = keystream_step(gen_state);
                expected_out_bytes.push_back(rotate_in_band(i_data_byte, gen_state,
                                                             decrypt_q));
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    prc_pkg::CFG_KEY_SEED: begin
                        key_seed_q = i_cfg_wdata[prc_pkg::StateW-1:0];
                    end
                    prc_pkg::CFG_CIPHER_MODE: begin
                        decrypt_q = i_cfg_wdata[0];
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_out_bytes.size();
    end

endmodule

/* tb/tb.sv */
// testbench top for the rotation stream cipher: clock, reset, config writes,
// directed and random byte streams under varying idle and stall patterns
// depends on prc_pkg, prng_rotation_stream_cipher and keystream_checker
`timescale 1ns / 100ps

module tb;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    prc_pkg::t_cfg_idx         i_cfg_index;
    logic [prc_pkg::CfgW-1:0]  i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [prc_pkg::ByteW-1:0] i_data_byte;
    logic                      i_restart;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [prc_pkg::ByteW-1:0] o_out_byte;
    int                        pending;
    int                        fail_count;
    int                        src_idle_pct;
    int                        sink_stall_pct;

    prng_rotation_stream_cipher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte)
    );

    keystream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_restart    (i_restart),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_byte   (o_out_byte),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // receiver stall, independent of the output valid
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // one byte transfer; entered and left at a falling edge
    task automatic send_byte(input prc_pkg::t_byte b, input logic rs);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_restart   <= rs;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // stop sending and wait until every predicted byte has come out
    task automatic drain_stream();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
    endtask

    // write both registers on consecutive cycles
    task automatic write_config(input prc_pkg::t_state key, input logic dec);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= prc_pkg::CFG_KEY_SEED;
        i_cfg_wdata <= key;
        @(negedge i_clk);
        i_cfg_index <= prc_pkg::CFG_CIPHER_MODE;
        i_cfg_wdata <= prc_pkg::CfgW'(dec);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // stimulus
    initial begin
        prc_pkg::t_state key;
        logic            dec;
        logic            rs;
        prc_pkg::t_byte  b;
        int              sent;
        int              msg_len;

        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = prc_pkg::CFG_KEY_SEED;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_data_byte    = '0;
        i_restart      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers, generator running on from its reset value
        send_byte(8'd65, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd255, 1'b0);
        drain_stream();

        // largest legal key, encrypt, band edges and their neighbors
        write_config(17'd65536, 1'b0);
        send_byte(8'd32, 1'b1);
        send_byte(8'd127, 1'b0);
        send_byte(8'd31, 1'b0);
        send_byte(8'd128, 1'b0);
        send_byte(8'd126, 1'b0);
        send_byte(8'd33, 1'b0);
        drain_stream();

        // decrypt
        write_config(17'd65536, 1'b1);
        send_byte(8'd32, 1'b1);
        send_byte(8'd127, 1'b0);
        send_byte(8'd200, 1'b0);
        send_byte(8'd65, 1'b0);
        drain_stream();

        // zero key: generator stuck at zero, no rotation
        write_config(17'd0, 1'b0);
        send_byte(8'd65, 1'b1);
        send_byte(8'd122, 1'b0);
        send_byte(8'd127, 1'b0);
        drain_stream();

        // key above the modulus range
        write_config(17'h1FFFF, 1'b1);
        send_byte(8'd32, 1'b1);
        send_byte(8'd100, 1'b0);
        send_byte(8'd127, 1'b0);
        drain_stream();

        // smallest legal key
        write_config(17'd1, 1'b0);
        send_byte(8'd90, 1'b1);
        drain_stream();

        // random messages: restart on most first bytes and on rare others, mostly printable text
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin key = 17'd1;     dec = 1'b0; end
                1: begin key = 17'd65536; dec = 1'b1; end
                2: begin key = 17'h1FFFF; dec = 1'b0; end
                default: begin
                    case ($urandom_range(9))
                        0:       key = 17'd0;
                        1:       key = 17'($urandom_range(65537, 131071));
                        default: key = 17'($urandom_range(1, 65536));
                    endcase
                    dec = 1'($urandom_range(1));
                end
            endcase
            write_config(key, dec);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            sent = 0;
            while (sent < 112) begin
                msg_len = $urandom_range(1, 40);
                for (int j = 0; j < msg_len && sent < 112; j++) begin
                    if (j == 0) begin
                        rs = ($urandom_range(9) != 0);
                    end else begin
                        rs = ($urandom_range(49) == 0);
                    end
                    if ($urandom_range(99) < 85) begin
                        b = 8'($urandom_range(32, 127));
                    end else begin
                        b = 8'($urandom_range(255));
                    end
                    send_byte(b, rs);
                    sent++;
                end
            end
            drain_stream();
        end

        // verdict
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/prc_pkg.sv
hw/rtl/prng_rotation_stream_cipher.sv
tb/keystream_checker.sv
tb/tb.sv
